@@ rtl/chm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants for the chained hash map
// Sequencer states, register map, field widths and the remainder digit step.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int CFG_W       = 9;    // bucket_count register width
    localparam int KEY_W       = 64;
    localparam int IN_VALUE_W  = 16;   // value field width on the stream
    localparam int DIGIT_BITS  = 8;    // key bits folded into the remainder per cycle
    localparam int DIGIT_STEPS = KEY_W / DIGIT_BITS;
    localparam int STEP_W      = $clog2(DIGIT_STEPS);
    localparam int ADDR_W      = 3;

    localparam logic [ADDR_W-1:0] ADDR_BUCKET_COUNT  = 3'd0;
    localparam logic [CFG_W-1:0]  BUCKET_COUNT_RESET = 9'd256;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MOD   = 6'b000010,
        S_HEAD  = 6'b000100,
        S_HWAIT = 6'b001000,
        S_CMP   = 6'b010000,
        S_UPD   = 6'b100000
    } state_t;

    // Restoring remainder over one digit, MSB first; r_in < n on entry.
    function automatic logic [CFG_W-1:0] rem_digit(input logic [CFG_W-1:0] r_in,
                                                   input logic [DIGIT_BITS-1:0] d,
                                                   input logic [CFG_W-1:0] n);
        logic [CFG_W-1:0] r;
        logic [CFG_W:0]   t;
        r = r_in;
        for (int i = DIGIT_BITS - 1; i >= 0; i--) begin
            t = {r, d[i]};
            if (t >= {1'b0, n}) begin
                t = t - {1'b0, n};
            end
            r = t[CFG_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/chained_hash_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map: key-value map with separate chaining over a node pool
// Insert/overwrite or lookup of 64-bit keys; bucket = key mod clamp(bucket_count).
// ----------------------------------------------------------------------------
//  port group   dir   contents
//  s_*          in    tuser = mode, tdata = key, value
//  m_*          out   tdata = hit, value_out, added, pool_full, entry_count
//  APB          cfg   register 0 at 0x0: bucket_count
//
//  An item passes through the remainder unit (8 key bits a cycle), then the
//  head RAM read, then for a used bucket the node RAM read and one compare
//  per chain node visited, and last the update state; an empty bucket goes
//  straight from the head check to the update state.
//  Reset clears the bucket valid bits and the entry count; no clearing pass.
//  s_tready is high only between items and rises with m_tvalid; a result
//  still waiting on m_tready holds the next item in its update cycle.
// ----------------------------------------------------------------------------
module chained_hash_map
    import chm_pkg::*;
#(
    parameter int BUCKETS    = 256,
    parameter int NODES      = 4096,
    parameter int VALUE_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [KEY_W+IN_VALUE_W-1:0]       s_tdata,   // key[63:0], value[79:64]
    input  logic                              s_tuser,   // mode
    // stream out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // hit[0], value_out[16:1], added[17], pool_full[18], entry_count[..:19]
    output logic [((19+$clog2(NODES+1)+7)/8)*8-1:0] m_tdata,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ADDR_W-1:0]                 paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int NIDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int BIDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CNT_W  = $clog2(NODES + 1);
    localparam int VW     = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;
    localparam int OUT_W  = ((19 + CNT_W + 7) / 8) * 8;

    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      bucket_count_reg;
    logic                  mode_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VW-1:0]         value_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [CFG_W-1:0]      rem_reg;
    logic [NIDX_W-1:0]     cur_reg;
    logic                  found_reg;
    logic [VW-1:0]         found_val_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [BUCKETS-1:0]    head_valid_reg;
    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg;

    logic [CFG_W-1:0]      eff_n;
    logic [BIDX_W-1:0]     bucket;
    logic                  in_accept;
    logic                  out_free;
    logic                  upd_fire;
    logic                  pool_empty;
    logic                  do_alloc;
    logic                  do_overwrite;
    logic                  key_match;
    logic [NIDX_W-1:0]     alloc_idx;
    logic [CNT_W-1:0]      cnt_after;
    logic                  r_hit, r_added, r_full;
    logic [IN_VALUE_W-1:0] r_value;

    logic [NIDX_W-1:0]     head_rdata;
    logic [KEY_W-1:0]      key_rdata;
    logic [VW-1:0]         val_rdata;
    logic [NIDX_W:0]       next_rdata;       // {valid, index}
    logic [NIDX_W-1:0]     node_raddr;
    logic [NIDX_W-1:0]     node_waddr;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BUCKET_COUNT) ? 32'(bucket_count_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= BUCKET_COUNT_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_BUCKET_COUNT) begin
            bucket_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        if (bucket_count_reg == '0) begin
            eff_n = CFG_W'(1);
        end else if (int'(bucket_count_reg) > BUCKETS) begin
            eff_n = CFG_W'(BUCKETS);
        end else begin
            eff_n = bucket_count_reg;
        end
    end

    // ---------------- datapath decisions ----------------
    assign bucket       = BIDX_W'(rem_reg);
    assign in_accept    = s_tvalid && s_tready;
    assign s_tready     = (state_reg == S_IDLE);
    assign out_free     = !m_tvalid_reg || m_tready;
    assign upd_fire     = (state_reg == S_UPD) && out_free;
    assign pool_empty   = (cnt_reg == CNT_W'(NODES));
    assign alloc_idx    = cnt_reg[NIDX_W-1:0];
    assign key_match    = (key_rdata == key_reg);
    assign do_overwrite = (mode_reg == MODE_INSERT) && found_reg;
    assign do_alloc     = (mode_reg == MODE_INSERT) && !found_reg && !pool_empty;
    assign cnt_after    = do_alloc ? cnt_reg + CNT_W'(1) : cnt_reg;

    assign r_hit   = found_reg;
    assign r_added = do_alloc;
    assign r_full  = (mode_reg == MODE_INSERT) && !found_reg && pool_empty;
    assign r_value = (mode_reg == MODE_LOOKUP && found_reg) ? IN_VALUE_W'(found_val_reg)
                                                             : '0;

    always_comb begin
        unique case (state_reg)
            S_HWAIT: node_raddr = head_rdata;
            S_CMP:   node_raddr = next_rdata[NIDX_W-1:0];
            default: node_raddr = cur_reg;
        endcase
    end

    assign node_waddr = do_alloc ? alloc_idx : cur_reg;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) state_next = S_MOD;
            end
            S_MOD: begin
                if (step_reg == STEP_W'(DIGIT_STEPS - 1)) state_next = S_HEAD;
            end
            S_HEAD: begin
                state_next = head_valid_reg[bucket] ? S_HWAIT : S_UPD;
            end
            S_HWAIT: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (key_match || !next_rdata[NIDX_W]) state_next = S_UPD;
            end
            S_UPD: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            head_valid_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (upd_fire) begin
                cnt_reg      <= cnt_after;
                m_tvalid_reg <= 1'b1;
                if (do_alloc) begin
                    head_valid_reg[bucket] <= 1'b1;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            mode_reg  <= s_tuser;
            key_reg   <= s_tdata[KEY_W-1:0];
            value_reg <= s_tdata[KEY_W +: VW];
            step_reg  <= '0;
            rem_reg   <= '0;
            found_reg <= 1'b0;
        end
        if (state_reg == S_MOD) begin
            // rotate so the key is whole again after the last digit
            rem_reg  <= rem_digit(rem_reg, key_reg[KEY_W-1 -: DIGIT_BITS], eff_n);
            key_reg  <= {key_reg[KEY_W-DIGIT_BITS-1:0], key_reg[KEY_W-1 -: DIGIT_BITS]};
            step_reg <= step_reg + STEP_W'(1);
        end
        if (state_reg == S_HWAIT) begin
            cur_reg <= head_rdata;
        end
        if (state_reg == S_CMP) begin
            if (key_match) begin
                found_reg     <= 1'b1;
                found_val_reg <= val_rdata;
            end else if (next_rdata[NIDX_W]) begin
                cur_reg <= next_rdata[NIDX_W-1:0];
            end
        end
        if (upd_fire) begin
            m_tdata_reg <= OUT_W'({cnt_after, r_full, r_added, r_value, r_hit});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- storage ----------------
    chm_ram #(.WIDTH(NIDX_W), .DEPTH(BUCKETS)) u_head (
        .aclk  (aclk),
        .we    (upd_fire && do_alloc),
        .waddr (bucket),
        .wdata (alloc_idx),
        .raddr (bucket),
        .rdata (head_rdata)
    );

    chm_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_node_key (
        .aclk  (aclk),
        .we    (upd_fire && do_alloc),
        .waddr (node_waddr),
        .wdata (key_reg),
        .raddr (node_raddr),
        .rdata (key_rdata)
    );

    chm_ram #(.WIDTH(VW), .DEPTH(NODES)) u_node_value (
        .aclk  (aclk),
        .we    (upd_fire && (do_alloc || do_overwrite)),
        .waddr (node_waddr),
        .wdata (value_reg),
        .raddr (node_raddr),
        .rdata (val_rdata)
    );

    chm_ram #(.WIDTH(NIDX_W + 1), .DEPTH(NODES)) u_node_next (
        .aclk  (aclk),
        .we    (upd_fire && do_alloc),
        .waddr (node_waddr),
        .wdata ({head_valid_reg[bucket], head_rdata}),
        .raddr (node_raddr),
        .rdata (next_rdata)
    );

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(NODES))
        else $error("entry count beyond pool size");

    a_result_from_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_UPD))
        else $error("result raised outside update cycle");

    a_alloc_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd_fire && do_alloc) |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("allocation did not advance entry count");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_fire |-> !(r_hit && r_added) && !(r_added && r_full) && !(r_hit && r_full))
        else $error("conflicting result flags");

    a_rem_below_n: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_HEAD) |-> rem_reg < eff_n)
        else $error("bucket index not below bucket count");
`endif

endmodule

@@ rtl/chm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ tb/chained_hash_map_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map_tb: self-checking bench for the chained hash map
// Streams insert and lookup items through the map, predicts every result with
// a behavioural copy of the chained table and node pool, and compares each
// result field by field. Covers bucket count extremes and changes with live
// entries.
// ----------------------------------------------------------------------------
module chained_hash_map_tb
    import chm_pkg::*;
();

    localparam int NODE_POOL   = 4096;
    localparam int BUCKET_MAX  = 256;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic        mode;
        logic [63:0] key;
        logic [15:0] value;
    } map_req_t;

    // declared MSB first so that a cast of m_tdata lines up with the port
    typedef struct packed {
        logic [12:0] entry_count;
        logic        pool_full;
        logic        added;
        logic [15:0] value_out;
        logic        hit;
    } map_resp_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [79:0]       s_tdata  = '0;   // key[63:0], value[79:64]
    logic              s_tuser  = 1'b0; // mode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // hit[0], value_out[16:1], added[17], pool_full[18], entry_count[31:19]
    logic [31:0]       m_tdata;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    chained_hash_map dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---- predicted map state ----
    bit                 head_ok   [BUCKET_MAX];
    bit [12:0]          head_at   [BUCKET_MAX];
    bit [63:0]          slot_key  [NODE_POOL];
    bit [15:0]          slot_value[NODE_POOL];
    bit [12:0]          slot_next [NODE_POOL];
    bit                 next_ok   [NODE_POOL];
    int unsigned        used_slots = 0;
    logic [CFG_W-1:0]   bucket_reg = BUCKET_COUNT_RESET;

    map_req_t           req_q[$];
    map_req_t           req_cur;
    bit                 req_taken = 1'b0;
    map_resp_t          due_resp_q[$];
    logic [63:0]        key_log[$];
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 mismatch_cnt   = 0;
    int                 cycle_cnt      = 0;

    function automatic map_resp_t map_access(map_req_t rq);
        map_resp_t   rs;
        int unsigned n_buckets;
        int unsigned b;
        int unsigned cur;
        int unsigned steps;
        bit          have;
        bit          found;
        rs = '0;
        found = 1'b0;
        n_buckets = 32'(bucket_reg);
        if (n_buckets < 1) n_buckets = 1;
        if (n_buckets > BUCKET_MAX) n_buckets = BUCKET_MAX;
        b = 32'(rq.key % 64'(n_buckets));
        have = head_ok[b];
        cur = 32'(head_at[b]);
        steps = 0;
        while (have && cur < NODE_POOL && steps < NODE_POOL && !found) begin
            if (slot_key[cur] == rq.key) begin
                found = 1'b1;
            end else begin
                have = next_ok[cur];
                cur = 32'(slot_next[cur]);
                steps++;
            end
        end
        if (rq.mode == MODE_LOOKUP) begin
            if (found) begin
                rs.hit = 1'b1;
                rs.value_out = slot_value[cur];
            end
        end else if (found) begin
            slot_value[cur] = rq.value;
            rs.hit = 1'b1;
        end else if (used_slots >= NODE_POOL) begin
            rs.pool_full = 1'b1;
        end else begin
            // new node goes to the head of its chain
            slot_key[used_slots]   = rq.key;
            slot_value[used_slots] = rq.value;
            slot_next[used_slots]  = head_at[b];
            next_ok[used_slots]    = head_ok[b];
            head_at[b] = 13'(used_slots);
            head_ok[b] = 1'b1;
            used_slots++;
            rs.added = 1'b1;
        end
        rs.entry_count = 13'(used_slots);
        return rs;
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    // ---- driver: one item per handshake, random gaps ----
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            req_taken = 1'b0;
            if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req_cur = req_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {req_cur.value, req_cur.key};
                s_tuser  <= req_cur.mode;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---- monitor: predict on accept, check on result ----
    always @(posedge aclk) begin
        map_resp_t want;
        map_resp_t got;
        if (aresetn && s_tvalid && s_tready) begin
            due_resp_q.push_back(map_access(req_cur));
            req_taken = 1'b1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = map_resp_t'(m_tdata);
            if (due_resp_q.size() == 0) begin
                flag_mismatch($sformatf("result with nothing pending: %h", m_tdata));
            end else begin
                want = due_resp_q.pop_front();
                if (got !== want) begin
                    flag_mismatch($sformatf(
                        "exp/got hit %0b/%0b value_out %h/%h added %0b/%0b full %0b/%0b count %0d/%0d",
                        want.hit, got.hit, want.value_out, got.value_out, want.added, got.added,
                        want.pool_full, got.pool_full, want.entry_count, got.entry_count));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---- stimulus ----
    task automatic push_req(logic mode, logic [63:0] key, logic [15:0] value);
        map_req_t rq;
        rq.mode  = mode;
        rq.key   = key;
        rq.value = value;
        req_q.push_back(rq);
    endtask

    task automatic wait_drained();
        while (!(req_q.size() == 0 && !s_tvalid && due_resp_q.size() == 0)) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_idling(int sel);
        case (sel)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    // write only with the map idle, then read back the raw register
    task automatic write_buckets(logic [31:0] val);
        logic [31:0] rd;
        wait_drained();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_BUCKET_COUNT;
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        bucket_reg = val[CFG_W-1:0];
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rd = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {{(32-CFG_W){1'b0}}, bucket_reg}) begin
            flag_mismatch($sformatf("bucket_count readback exp %0d got %h", bucket_reg, rd));
        end
    endtask

    function automatic logic [63:0] fresh_key();
        if ($urandom_range(3) == 0) return 64'($urandom_range(2000));
        return {$urandom, $urandom};
    endfunction

    task automatic random_items(int n);
        map_req_t rq;
        int       r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            rq.value = 16'($urandom);
            if (key_log.size() == 0 || r < 30) begin
                rq.mode = MODE_INSERT;
                rq.key  = fresh_key();
                key_log.push_back(rq.key);
            end else if (r < 50) begin
                rq.mode = MODE_INSERT;
                rq.key  = key_log[$urandom_range(key_log.size() - 1)];
            end else if (r < 85) begin
                rq.mode = MODE_LOOKUP;
                rq.key  = key_log[$urandom_range(key_log.size() - 1)];
            end else begin
                rq.mode = MODE_LOOKUP;
                rq.key  = fresh_key();
            end
            req_q.push_back(rq);
        end
    endtask

    initial begin
        int phase_cfg[9];
        phase_cfg = '{256, 37, 511, 300, 7, 128, 1, 0, 256};
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty map, key and value extremes, chains in one bucket
        set_idling(0);
        push_req(MODE_LOOKUP, 64'd0, 16'hFFFF);
        push_req(MODE_INSERT, 64'd0, 16'h0000);
        push_req(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        push_req(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
        push_req(MODE_LOOKUP, 64'd0, 16'h1234);
        push_req(MODE_INSERT, 64'd256, 16'h1234);
        push_req(MODE_LOOKUP, 64'd256, 16'h0000);
        push_req(MODE_LOOKUP, 64'd0, 16'h0000);
        push_req(MODE_INSERT, 64'd0, 16'hABCD);
        push_req(MODE_LOOKUP, 64'd0, 16'h0000);
        push_req(MODE_LOOKUP, 64'd512, 16'h0000);
        push_req(MODE_INSERT, 64'h8000_0000_0000_0000, 16'h8000);
        push_req(MODE_INSERT, 64'h5555_5555_5555_5555, 16'h5555);
        push_req(MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA);
        push_req(MODE_LOOKUP, 64'h5555_5555_5555_5555, 16'hFFFF);
        push_req(MODE_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 16'h0000);
        push_req(MODE_LOOKUP, 64'h8000_0000_0000_0000, 16'h0000);
        push_req(MODE_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 16'h0000);
        key_log.push_back(64'd0);
        key_log.push_back(64'd256);
        key_log.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        key_log.push_back(64'h5555_5555_5555_5555);

        // single bucket with entries already stored: the top key rehashes
        // away from its node, so its re-insert adds a second one
        write_buckets(1);
        push_req(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
        push_req(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0001);
        push_req(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
        push_req(MODE_LOOKUP, 64'd256, 16'h0000);

        // random phases over several moduli, out-of-range ones included
        for (int p = 0; p < 9; p++) begin
            write_buckets(phase_cfg[p]);
            set_idling(p % 4);
            random_items(phase_cfg[p] <= 1 ? 40 : 190);
        end

        // back to the full table, then a small odd modulus
        write_buckets(256);
        set_idling(0);
        random_items(60);
        wait_drained();
        write_buckets(3);
        set_idling(2);
        random_items(40);

        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/chm_pkg.sv
rtl/chm_ram.sv
rtl/chained_hash_map.sv
tb/chained_hash_map_tb.sv
